FILE: rtl/core/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg
// Shared types and constants for the LEB128 varint decoder.
// ----------------------------------------------------------------------------
package leb_pkg;

	localparam int unsigned VALUE_W = 64;
	localparam int unsigned COUNT_W = 4;
	localparam int unsigned SHIFT_W = 7;

	localparam int unsigned CONT_BIT_IDX = 7;
	localparam int unsigned SIGN_BIT_IDX = 6;

	localparam logic [COUNT_W-1:0] MAX_BYTES_NARROW = COUNT_W'(5);
	localparam logic [COUNT_W-1:0] MAX_BYTES_WIDE   = COUNT_W'(10);

	localparam logic [SHIFT_W-1:0] SHIFT_STEP   = SHIFT_W'(7);
	localparam logic [SHIFT_W-1:0] WIDTH_NARROW = SHIFT_W'(32);
	localparam logic [SHIFT_W-1:0] WIDTH_WIDE   = SHIFT_W'(64);

	localparam logic [VALUE_W-1:0] NARROW_MASK = {{(VALUE_W/2){1'b0}}, {(VALUE_W/2){1'b1}}};

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERLONG  = 2'd1,
		ST_TRUNCATED = 2'd2
	} status_t;

endpackage

FILE: rtl/core/leb_in_if.sv
// ----------------------------------------------------------------------------
// leb_in_if
// Byte channel into the decoder: one encoded byte and its flags per item.
// ----------------------------------------------------------------------------
interface leb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_signed;
	logic       is_wide;
	logic       at_buffer_end;

	modport source (
		output valid, data_byte, is_signed, is_wide, at_buffer_end,
		input  ready
	);

	modport sink (
		input  valid, data_byte, is_signed, is_wide, at_buffer_end,
		output ready
	);
endinterface

FILE: rtl/core/leb_out_if.sv
// ----------------------------------------------------------------------------
// leb_out_if
// Result channel out of the decoder: one decoded value per item.
// ----------------------------------------------------------------------------
interface leb_out_if
	import leb_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [VALUE_W-1:0]   decoded_value;
	logic [COUNT_W-1:0]   byte_count;
	status_t              status;

	modport source (
		output valid, decoded_value, byte_count, status,
		input  ready
	);

	modport sink (
		input  valid, decoded_value, byte_count, status,
		output ready
	);
endinterface

FILE: rtl/core/leb128_varint_decoder.sv
// ----------------------------------------------------------------------------
// leb128_varint_decoder: LEB128 decoder, one encoded byte per item
// The last byte is held in the input register, then decoded into the result
// register once that register is empty or its result is being taken.
// Throughput: 1 byte per cycle while the result register can take a result.
// A result that is not taken holds the result register, then the input.
// Reset: arst_n clears the open value, the mode latch and all valid flags.
// ----------------------------------------------------------------------------
module leb128_varint_decoder
	import leb_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	leb_in_if.sink        byte_ch,
	leb_out_if.source     value_ch
);

	// input register
	logic               valid_s1;
	logic [7:0]         data_s1;
	logic               signed_s1;
	logic               wide_s1;
	logic               end_s1;

	// open value state
	logic [VALUE_W-1:0] acc_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [COUNT_W-1:0] taken_q;
	logic               lat_signed_q;
	logic               lat_wide_q;

	// result register
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [COUNT_W-1:0] out_count_q;
	status_t            out_status_q;

	logic               advance;
	logic               first;
	logic               cur_signed;
	logic               cur_wide;
	logic [VALUE_W-1:0] acc_base;
	logic [SHIFT_W-1:0] shift_base;
	logic [COUNT_W-1:0] taken_base;
	logic [VALUE_W-1:0] acc_next;
	logic [COUNT_W-1:0] taken_next;
	logic [SHIFT_W-1:0] shift_next;
	logic [COUNT_W-1:0] limit;
	logic [SHIFT_W-1:0] width;
	logic               done;
	status_t            res_status;
	logic [VALUE_W-1:0] res_value;

	// decode the held byte only when the result register can take a result
	assign advance       = valid_s1 && (!out_valid_q || value_ch.ready);
	assign byte_ch.ready = !valid_s1 || advance;

	always_comb begin
		first      = (taken_q == '0);
		cur_signed = first ? signed_s1 : lat_signed_q;
		cur_wide   = first ? wide_s1   : lat_wide_q;
		acc_base   = first ? '0 : acc_q;
		shift_base = first ? '0 : shift_q;
		taken_base = first ? '0 : taken_q;

		acc_next = acc_base;
		if (shift_base < WIDTH_WIDE) begin
			acc_next = acc_base | ({{(VALUE_W-7){1'b0}}, data_s1[6:0]} << shift_base);
		end
		taken_next = taken_base + COUNT_W'(1);
		shift_next = shift_base + SHIFT_STEP;
		limit      = cur_wide ? MAX_BYTES_WIDE : MAX_BYTES_NARROW;
		width      = cur_wide ? WIDTH_WIDE : WIDTH_NARROW;

		done       = 1'b1;
		res_status = ST_OK;
		res_value  = '0;
		if (data_s1[CONT_BIT_IDX]) begin
			if (taken_next >= limit) begin
				res_status = ST_OVERLONG;
			end else if (end_s1) begin
				res_status = ST_TRUNCATED;
			end else begin
				done = 1'b0;
			end
		end else begin
			res_value = acc_next;
			if (cur_signed && (shift_next < width) && data_s1[SIGN_BIT_IDX]) begin
				res_value = res_value | ({VALUE_W{1'b1}} << shift_next);
			end
			if (!cur_wide) begin
				res_value = res_value & NARROW_MASK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			data_s1   <= byte_ch.data_byte;
			signed_s1 <= byte_ch.is_signed;
			wide_s1   <= byte_ch.is_wide;
			end_s1    <= byte_ch.at_buffer_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			shift_q      <= '0;
			taken_q      <= '0;
			lat_signed_q <= 1'b0;
			lat_wide_q   <= 1'b0;
		end else if (advance) begin
			if (done) begin
				acc_q        <= '0;
				shift_q      <= '0;
				taken_q      <= '0;
				lat_signed_q <= 1'b0;
				lat_wide_q   <= 1'b0;
			end else begin
				acc_q        <= acc_next;
				shift_q      <= shift_next;
				taken_q      <= taken_next;
				lat_signed_q <= cur_signed;
				lat_wide_q   <= cur_wide;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= done;
		end else if (value_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && done) begin
			out_value_q  <= res_value;
			out_count_q  <= taken_next;
			out_status_q <= res_status;
		end
	end

	assign value_ch.valid         = out_valid_q;
	assign value_ch.decoded_value = out_value_q;
	assign value_ch.byte_count    = out_count_q;
	assign value_ch.status        = out_status_q;

`ifndef SYNTHESIS
	a_open_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(lat_wide_q ? (taken_q < MAX_BYTES_WIDE) : (taken_q < MAX_BYTES_NARROW)))
		else $error("open value holds as many bytes as the limit");

	a_shift_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		shift_q == SHIFT_W'(taken_q) * SHIFT_STEP)
		else $error("shift position out of step with byte count");

	a_error_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != ST_OK)) |-> (out_value_q == '0))
		else $error("error result carries a nonzero value");

	a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && done && !cur_wide) |=> (out_value_q[VALUE_W-1:VALUE_W/2] == '0))
		else $error("32-bit result has upper half set");
`endif

endmodule
